@@ hw/rtl/psts_pkg.sv @@
`timescale 1ns / 1ps

package psts_pkg;

   typedef enum logic [1:0] {
      FN_PUSH   = 2'd0,
      FN_POP    = 2'd1,
      FN_INSERT = 2'd2,
      FN_QUERY  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_EMPTY   = 2'd1,
      STS_NO_TERM = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_PLAIN_MAX   = 3'd0,
      CSR_INT_CODE    = 3'd1,
      CSR_FLOAT_CODE  = 3'd2,
      CSR_STRING_CODE = 3'd3,
      CSR_NIL_CODE    = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE,
      ST_SHIFT,
      ST_PLACE
   } state_type;

   typedef struct packed {
      logic signed [7:0] symbol;
      logic [7:0]        etype;
   } entry_type;

   typedef struct packed {
      logic [6:0]        plain_max;
      logic signed [7:0] int_code;
      logic signed [7:0] float_code;
      logic signed [7:0] string_code;
      logic signed [7:0] nil_code;
   } cfg_type;

   typedef struct packed {
      entry_type  top;
      logic       top_valid;
      entry_type  term;
      logic       term_found;
      logic [6:0] depth;
      status_type status;
   } rsp_type;

   localparam logic [6:0]        PLAIN_MAX_RST   = 7'd13;
   localparam logic signed [7:0] INT_CODE_RST    = 8'sd14;
   localparam logic signed [7:0] FLOAT_CODE_RST  = 8'sd15;
   localparam logic signed [7:0] STRING_CODE_RST = 8'sd16;
   localparam logic signed [7:0] NIL_CODE_RST    = 8'sd17;

   function automatic logic is_terminal(logic signed [7:0] sym, cfg_type cfg);
      logic by_range;
      by_range = !sym[7] && (sym[6:0] <= cfg.plain_max);
      return by_range || (sym == cfg.int_code) || (sym == cfg.float_code)
         || (sym == cfg.string_code) || (sym == cfg.nil_code);
   endfunction

endpackage

@@ hw/rtl/psts_ifs.sv @@
`timescale 1ns / 1ps

interface psts_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic signed [7:0] symbol;
   logic [7:0]        entry_type;

   modport source (output valid, func, symbol, entry_type, input ready);
   modport sink (input valid, func, symbol, entry_type, output ready);
endinterface

interface psts_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] top_symbol;
   logic [7:0]        top_type;
   logic              top_valid;
   logic signed [7:0] terminal_symbol;
   logic [7:0]        terminal_type;
   logic              terminal_found;
   logic [6:0]        depth;
   logic [1:0]        status;

   modport source (output valid, top_symbol, top_type, top_valid, terminal_symbol,
                   terminal_type, terminal_found, depth, status, input ready);
   modport sink (input valid, top_symbol, top_type, top_valid, terminal_symbol,
                 terminal_type, terminal_found, depth, status, output ready);
endinterface

interface psts_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/psts_csr.sv @@
`timescale 1ns / 1ps

module psts_csr (
   input  logic            clock,
   input  logic            reset,
   psts_csr_if.sink        csr_bus,
   output psts_pkg::cfg_type cfg
);

   psts_pkg::cfg_type cfg_ff;
   psts_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (psts_pkg::csr_index_type'(csr_bus.index))
            psts_pkg::CSR_PLAIN_MAX:   cfg_in.plain_max   = csr_bus.data[6:0];
            psts_pkg::CSR_INT_CODE:    cfg_in.int_code    = csr_bus.data;
            psts_pkg::CSR_FLOAT_CODE:  cfg_in.float_code  = csr_bus.data;
            psts_pkg::CSR_STRING_CODE: cfg_in.string_code = csr_bus.data;
            psts_pkg::CSR_NIL_CODE:    cfg_in.nil_code    = csr_bus.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plain_max   <= psts_pkg::PLAIN_MAX_RST;
         cfg_ff.int_code    <= psts_pkg::INT_CODE_RST;
         cfg_ff.float_code  <= psts_pkg::FLOAT_CODE_RST;
         cfg_ff.string_code <= psts_pkg::STRING_CODE_RST;
         cfg_ff.nil_code    <= psts_pkg::NIL_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/psts_mem.sv @@
`timescale 1ns / 1ps

module psts_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  psts_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output psts_pkg::entry_type rd_data
);

   psts_pkg::entry_type mem [DEPTH];
   psts_pkg::entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/psts_ctrl.sv @@
`timescale 1ns / 1ps

module psts_ctrl #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  psts_pkg::cfg_type   cfg,
   psts_req_if.sink            req_bus,
   psts_rsp_if.source          rsp_bus,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output psts_pkg::entry_type wr_data,
   output logic                rd_en,
   output logic [AW-1:0]       rd_addr,
   input  psts_pkg::entry_type rd_data
);

   psts_pkg::state_type  state_ff, state_in;
   psts_pkg::func_type   func_ff, func_in;
   psts_pkg::entry_type  new_ff, new_in;
   psts_pkg::entry_type  top_ff, top_in;
   psts_pkg::entry_type  term_ff, term_in;
   logic                 top_valid_ff, top_valid_in;
   logic                 found_ff, found_in;
   logic                 first_ff, first_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [AW-1:0]        term_idx_ff, term_idx_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   psts_pkg::rsp_type    rsp_ff, rsp_in;

   logic                 rsp_free;
   logic                 empty;
   logic                 full;
   logic [CW-1:0]        cnt_dec;
   logic [CW-1:0]        cnt_inc;
   logic [CW-1:0]        count_new;
   logic [CW+6:0]        count_ext;
   psts_pkg::status_type status_new;

   assign req_bus.ready           = (state_ff == psts_pkg::ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.top_symbol      = rsp_ff.top.symbol;
   assign rsp_bus.top_type        = rsp_ff.top.etype;
   assign rsp_bus.top_valid       = rsp_ff.top_valid;
   assign rsp_bus.terminal_symbol = rsp_ff.term.symbol;
   assign rsp_bus.terminal_type   = rsp_ff.term.etype;
   assign rsp_bus.terminal_found  = rsp_ff.term_found;
   assign rsp_bus.depth           = rsp_ff.depth;
   assign rsp_bus.status          = rsp_ff.status;

   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign cnt_dec   = count_ff - CW'(1);
   assign cnt_inc   = count_ff + CW'(1);
   assign count_ext = {7'b0, count_new};

   always_comb begin
      count_new  = count_ff;
      status_new = psts_pkg::STS_OK;
      unique case (func_ff)
         psts_pkg::FN_PUSH: begin
            if (full) status_new = psts_pkg::STS_FULL;
            else count_new = cnt_inc;
         end
         psts_pkg::FN_POP: begin
            if (empty) status_new = psts_pkg::STS_EMPTY;
            else count_new = cnt_dec;
         end
         psts_pkg::FN_INSERT: begin
            priority if (empty) status_new = psts_pkg::STS_EMPTY;
            else if (full) status_new = psts_pkg::STS_FULL;
            else if (!found_ff) status_new = psts_pkg::STS_NO_TERM;
            else count_new = cnt_inc;
         end
         psts_pkg::FN_QUERY: begin
            if (empty) status_new = psts_pkg::STS_EMPTY;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      new_in       = new_ff;
      top_in       = top_ff;
      term_in      = term_ff;
      top_valid_in = top_valid_ff;
      found_in     = found_ff;
      first_in     = first_ff;
      addr_in      = addr_ff;
      term_idx_in  = term_idx_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = new_ff;
      rd_en        = 1'b0;
      rd_addr      = cnt_dec[AW-1:0];

      unique case (state_ff)
         psts_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               func_in       = psts_pkg::func_type'(req_bus.func);
               new_in.symbol = req_bus.symbol;
               new_in.etype  = req_bus.entry_type;
               top_in        = '0;
               term_in       = '0;
               top_valid_in  = 1'b0;
               found_in      = 1'b0;
               first_in      = 1'b1;
               term_idx_in   = '0;
               addr_in       = cnt_dec[AW-1:0];
               if (empty) begin
                  state_in = psts_pkg::ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  state_in = psts_pkg::ST_SCAN;
               end
            end
         end

         psts_pkg::ST_SCAN: begin
            first_in = 1'b0;
            if (first_ff) begin
               top_in       = rd_data;
               top_valid_in = 1'b1;
            end
            if (psts_pkg::is_terminal(rd_data.symbol, cfg)) begin
               term_in     = rd_data;
               found_in    = 1'b1;
               term_idx_in = addr_ff;
               state_in    = psts_pkg::ST_DONE;
            end else if (addr_ff == '0) begin
               state_in = psts_pkg::ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = addr_ff - AW'(1);
               addr_in  = addr_ff - AW'(1);
            end
         end

         psts_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.top        = top_ff;
               rsp_in.top_valid  = top_valid_ff;
               rsp_in.term       = term_ff;
               rsp_in.term_found = found_ff;
               rsp_in.depth      = count_ext[6:0];
               rsp_in.status     = status_new;
               count_in          = count_new;
               state_in          = psts_pkg::ST_IDLE;
               if (status_new == psts_pkg::STS_OK) begin
                  if (func_ff == psts_pkg::FN_PUSH) begin
                     wr_en = 1'b1;
                  end else if (func_ff == psts_pkg::FN_INSERT) begin
                     if ((CW'(term_idx_ff) + CW'(1)) == count_ff) begin
                        wr_en = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        addr_in  = cnt_dec[AW-1:0];
                        state_in = psts_pkg::ST_SHIFT;
                     end
                  end
               end
            end
         end

         psts_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff + AW'(1);
            wr_data = rd_data;
            if (addr_ff == (term_idx_ff + AW'(1))) begin
               state_in = psts_pkg::ST_PLACE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = addr_ff - AW'(1);
               addr_in = addr_ff - AW'(1);
            end
         end

         psts_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = term_idx_ff + AW'(1);
            state_in = psts_pkg::ST_IDLE;
         end

         default: state_in = psts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psts_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      new_ff       <= new_in;
      top_ff       <= top_in;
      term_ff      <= term_in;
      top_valid_ff <= top_valid_in;
      found_ff     <= found_in;
      first_ff     <= first_in;
      addr_ff      <= addr_in;
      term_idx_ff  <= term_idx_in;
      rsp_ff       <= rsp_in;
   end

endmodule

@@ hw/rtl/precedence_stack_with_terminal_search_top.sv @@
`timescale 1ns / 1ps

// channel   direction  beat contents
// req_bus   in         func, symbol, entry_type
// rsp_bus   out        top entry, topmost terminal, depth, status
// csr_bus   in         register index, write data
//
// One request at a time. An empty stack is not read; otherwise a request reads
// entries from the top down to the topmost terminal (whole stack when none), one
// read of the stack memory per cycle. An insert with entries above that terminal
// moves each such entry up one place, then writes the new entry, through the single
// memory port pair after the response is posted.
// Reset is synchronous and empties the stack; stack memory is not cleared.
// A stalled response beat holds the controller before it posts the next.

module precedence_stack_with_terminal_search_top #(
   parameter int STACK_DEPTH = 64
) (
   input logic         clock,
   input logic         reset,
   psts_req_if.sink    req_bus,
   psts_rsp_if.source  rsp_bus,
   psts_csr_if.sink    csr_bus
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   psts_pkg::cfg_type   cfg;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   psts_pkg::entry_type wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   psts_pkg::entry_type rd_data;

   psts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   psts_mem #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   psts_ctrl #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

@@ bench/precedence_stack_with_terminal_search_top_test.sv @@
`timescale 1ns / 1ps

module precedence_stack_with_terminal_search_top_test;

   localparam int STACK_DEPTH = 64;
   localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 8;
   localparam int QUIET_LIMIT = 3000;

   typedef struct {
      psts_pkg::func_type fn;
      logic signed [7:0]  sym;
      logic [7:0]         typ;
   } stack_op_type;

   logic clock;
   logic reset;

   psts_req_if req_bus ();
   psts_rsp_if rsp_bus ();
   psts_csr_if csr_bus ();

   precedence_stack_with_terminal_search_top #(
      .STACK_DEPTH(STACK_DEPTH)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   stack_op_type          pending_ops[$];
   psts_pkg::rsp_type     predicted_views[$];

   psts_pkg::entry_type   stack_mem[STACK_DEPTH];
   int                    stack_count = 0;
   psts_pkg::cfg_type     term_cfg;

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count = 0;
   int rsp_beats = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit counts_as_terminal(logic signed [7:0] sym);
      int s;
      s = int'(sym);
      return (s >= 0 && s <= int'(term_cfg.plain_max)) || sym == term_cfg.int_code
         || sym == term_cfg.float_code || sym == term_cfg.string_code
         || sym == term_cfg.nil_code;
   endfunction

   function automatic psts_pkg::rsp_type apply_stack_op(psts_pkg::func_type fn,
                                                        logic signed [7:0] sym,
                                                        logic [7:0] typ);
      psts_pkg::rsp_type   view;
      psts_pkg::entry_type fresh;
      int                  n;
      int                  term_at;
      int                  i;
      view = '0;
      n = stack_count;
      term_at = -1;
      fresh.symbol = sym;
      fresh.etype = typ;
      if (n > 0) begin
         view.top = stack_mem[n - 1];
         view.top_valid = 1'b1;
      end
      for (i = n - 1; i >= 0 && term_at < 0; i--)
         if (counts_as_terminal(stack_mem[i].symbol)) term_at = i;
      if (term_at >= 0) begin
         view.term = stack_mem[term_at];
         view.term_found = 1'b1;
      end
      view.status = psts_pkg::STS_OK;
      case (fn)
         psts_pkg::FN_PUSH: begin
            if (n >= STACK_DEPTH) view.status = psts_pkg::STS_FULL;
            else begin
               stack_mem[n] = fresh;
               n++;
            end
         end
         psts_pkg::FN_POP: begin
            if (n == 0) view.status = psts_pkg::STS_EMPTY;
            else n--;
         end
         psts_pkg::FN_INSERT: begin
            if (n == 0) view.status = psts_pkg::STS_EMPTY;
            else if (n >= STACK_DEPTH) view.status = psts_pkg::STS_FULL;
            else if (term_at < 0) view.status = psts_pkg::STS_NO_TERM;
            else begin
               for (i = n; i > term_at + 1; i--) stack_mem[i] = stack_mem[i - 1];
               stack_mem[term_at + 1] = fresh;
               n++;
            end
         end
         default: begin
            if (n == 0) view.status = psts_pkg::STS_EMPTY;
         end
      endcase
      stack_count = n;
      view.depth = n[6:0];
      return view;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at response beat %0d: %s", rsp_beats, what);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   task automatic check_view();
      psts_pkg::rsp_type want;
      if (predicted_views.size() == 0) begin
         report_mismatch("response beat with nothing pending");
      end else begin
         want = predicted_views.pop_front();
         check_field("top_symbol", rsp_bus.top_symbol, want.top.symbol);
         check_field("top_type", rsp_bus.top_type, want.top.etype);
         check_field("top_valid", {7'd0, rsp_bus.top_valid}, {7'd0, want.top_valid});
         check_field("terminal_symbol", rsp_bus.terminal_symbol, want.term.symbol);
         check_field("terminal_type", rsp_bus.terminal_type, want.term.etype);
         check_field("terminal_found", {7'd0, rsp_bus.terminal_found},
                     {7'd0, want.term_found});
         check_field("depth", {1'b0, rsp_bus.depth}, {1'b0, want.depth});
         check_field("status", {6'd0, rsp_bus.status}, {6'd0, want.status});
      end
      rsp_beats++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.func <= psts_pkg::FN_QUERY;
         req_bus.symbol <= '0;
         req_bus.entry_type <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predicted_views.push_back(apply_stack_op(psts_pkg::func_type'(req_bus.func),
                                                     req_bus.symbol, req_bus.entry_type));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.func <= pending_ops[0].fn;
               req_bus.symbol <= pending_ops[0].sym;
               req_bus.entry_type <= pending_ops[0].typ;
               req_bus.valid <= 1'b1;
               pending_ops.delete(0);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_view();
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_op(psts_pkg::func_type fn, logic signed [7:0] sym, logic [7:0] typ);
      stack_op_type op;
      op.fn = fn;
      op.sym = sym;
      op.typ = typ;
      pending_ops.push_back(op);
   endtask

   task automatic write_csr(psts_pkg::csr_index_type idx, logic [7:0] value);
      csr_bus.index <= idx;
      csr_bus.data <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         psts_pkg::CSR_PLAIN_MAX:   term_cfg.plain_max = value[6:0];
         psts_pkg::CSR_INT_CODE:    term_cfg.int_code = value;
         psts_pkg::CSR_FLOAT_CODE:  term_cfg.float_code = value;
         psts_pkg::CSR_STRING_CODE: term_cfg.string_code = value;
         default:                   term_cfg.nil_code = value;
      endcase
   endtask

   task automatic drain();
      while (pending_ops.size() > 0 || req_bus.valid || predicted_views.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(int phase);
      logic [7:0] plain;
      logic [7:0] codes[4];
      int         k;
      plain = 8'($urandom);
      for (k = 0; k < 4; k++) codes[k] = 8'($urandom);
      if (phase == 0) begin
         plain = 8'h80;
         codes = '{8'h80, 8'h7f, 8'h00, 8'hff};
      end else if (phase == 1) begin
         plain = 8'h7f;
         codes = '{8'h80, 8'h80, 8'h80, 8'h80};
      end
      write_csr(psts_pkg::CSR_PLAIN_MAX, plain);
      write_csr(psts_pkg::CSR_INT_CODE, codes[0]);
      write_csr(psts_pkg::CSR_FLOAT_CODE, codes[1]);
      write_csr(psts_pkg::CSR_STRING_CODE, codes[2]);
      write_csr(psts_pkg::CSR_NIL_CODE, codes[3]);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic queue_random_ops(int count);
      bit                 grow;
      int                 seg_left;
      int                 roll;
      int                 pick;
      psts_pkg::func_type fn;
      logic signed [7:0]  sym;
      grow = 1'b0;
      seg_left = 0;
      repeat (count) begin
         if (seg_left == 0) begin
            grow = !grow;
            seg_left = $urandom_range(140, 40);
         end
         seg_left--;
         roll = $urandom_range(99);
         if (grow)
            fn = roll < 55 ? psts_pkg::FN_PUSH : roll < 80 ? psts_pkg::FN_INSERT
               : roll < 92 ? psts_pkg::FN_POP : psts_pkg::FN_QUERY;
         else
            fn = roll < 65 ? psts_pkg::FN_POP : roll < 77 ? psts_pkg::FN_PUSH
               : roll < 88 ? psts_pkg::FN_INSERT : psts_pkg::FN_QUERY;
         pick = $urandom_range(9);
         if (pick < 4) begin
            sym = 8'($urandom_range(int'(term_cfg.plain_max), 0));
         end else if (pick < 6) begin
            case ($urandom_range(3))
               0:       sym = term_cfg.int_code;
               1:       sym = term_cfg.float_code;
               2:       sym = term_cfg.string_code;
               default: sym = term_cfg.nil_code;
            endcase
         end else begin
            sym = 8'($urandom);
         end
         queue_op(fn, sym, 8'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = psts_pkg::CSR_PLAIN_MAX;
      csr_bus.data = '0;
      term_cfg.plain_max = psts_pkg::PLAIN_MAX_RST;
      term_cfg.int_code = psts_pkg::INT_CODE_RST;
      term_cfg.float_code = psts_pkg::FLOAT_CODE_RST;
      term_cfg.string_code = psts_pkg::STRING_CODE_RST;
      term_cfg.nil_code = psts_pkg::NIL_CODE_RST;
      send_idle_pct = 32;
      recv_idle_pct = 47;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty stack, no terminal, range bounds and every literal code
      queue_op(psts_pkg::FN_POP, 8'sd3, 8'h11);
      queue_op(psts_pkg::FN_QUERY, 8'sd0, 8'h00);
      queue_op(psts_pkg::FN_INSERT, 8'sd7, 8'h22);
      queue_op(psts_pkg::FN_PUSH, -8'sd128, 8'hff);
      queue_op(psts_pkg::FN_PUSH, 8'sd127, 8'h00);
      queue_op(psts_pkg::FN_INSERT, 8'sd5, 8'h33);
      queue_op(psts_pkg::FN_QUERY, 8'sd0, 8'h00);
      queue_op(psts_pkg::FN_PUSH, 8'sd0, 8'h5a);
      queue_op(psts_pkg::FN_PUSH, 8'sd20, 8'h44);
      queue_op(psts_pkg::FN_PUSH, 8'sd13, 8'ha5);
      queue_op(psts_pkg::FN_PUSH, 8'sd14, 8'h66);
      queue_op(psts_pkg::FN_PUSH, -8'sd1, 8'h77);
      queue_op(psts_pkg::FN_INSERT, 8'sd3, 8'h3c);
      queue_op(psts_pkg::FN_QUERY, 8'sd0, 8'h00);
      queue_op(psts_pkg::FN_PUSH, 8'sd15, 8'h88);
      queue_op(psts_pkg::FN_PUSH, 8'sd16, 8'h99);
      queue_op(psts_pkg::FN_PUSH, 8'sd17, 8'haa);
      queue_op(psts_pkg::FN_INSERT, -8'sd128, 8'hff);
      queue_op(psts_pkg::FN_POP, 8'sd0, 8'h00);
      queue_op(psts_pkg::FN_POP, 8'sd0, 8'h00);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         load_config(phase);
         send_idle_pct = phase < 2 ? 32 : phase < 4 ? 47 : 0;
         recv_idle_pct = phase < 2 ? 47 : phase < 4 ? 32 : 0;
         queue_random_ops(115);
      end
      drain();

      if (mismatch_count == 0 && predicted_views.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/psts_pkg.sv
hw/rtl/psts_ifs.sv
hw/rtl/psts_csr.sv
hw/rtl/psts_mem.sv
hw/rtl/psts_ctrl.sv
hw/rtl/precedence_stack_with_terminal_search_top.sv
bench/precedence_stack_with_terminal_search_top_test.sv
